// ===== rtl/digit_glyph_page_renderer_defines.svh =====
// Assertion macros shared by the digit glyph page renderer RTL.
// No dependencies; included by the top level only.
`ifndef DIGIT_GLYPH_PAGE_RENDERER_DEFINES_SVH
`define DIGIT_GLYPH_PAGE_RENDERER_DEFINES_SVH

`ifndef ASSERT_OFF
`define DGPR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("dgpr assertion failed");
`define DGPR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("dgpr assertion failed");
`else
`define DGPR_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define DGPR_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/dgpr_pkg.sv =====
// Types, constants and font ROM of the digit glyph page renderer.
// No dependencies.
package dgpr_pkg;

  typedef logic [3:0] glyph_t;

  typedef struct packed {
    logic       kind;
    logic [2:0] page;
    logic [6:0] column;
    glyph_t     glyph;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharSlash = 8'h2F;

  localparam glyph_t GlyphColon = 4'd10;
  localparam glyph_t GlyphDash  = 4'd11;

  localparam logic [7:0] CmdPageBase = 8'hB0;
  localparam logic [3:0] CmdColLow   = 4'h0;
  localparam logic [3:0] CmdColHigh  = 4'h1;

  localparam logic [4:0] StepColLow    = 5'd1;
  localparam logic [4:0] StepColHigh   = 5'd2;
  localparam logic [4:0] StepFirstData = 5'd3;
  localparam logic [4:0] StepLastSmall = 5'd10;
  localparam logic [4:0] StepLastLarge = 5'd18;

  localparam logic KindSmall = 1'b0;
  localparam logic KindLarge = 1'b1;

  // {drawable, glyph index}
  function automatic logic [4:0] classify(logic kind, logic [7:0] code);
    logic [4:0] res;
    res = '0;
    if (code >= CharZero && code <= CharNine) begin
      res = {1'b1, 4'(code - CharZero)};
    end else if (code == CharColon) begin
      res = {1'b1, GlyphColon};
    end else if (code == CharSlash && kind == KindLarge) begin
      res = {1'b1, GlyphDash};
    end
    return res;
  endfunction

  // column 0 in the low byte, bit 0 is the top row
  function automatic logic [7:0] glyph_col(glyph_t g, logic [2:0] c);
    logic [63:0] row;
    case (g)
      4'd0:    row = 64'h00_00_00_3E_45_49_51_3E;
      4'd1:    row = 64'h00_00_00_00_40_7F_42_00;
      4'd2:    row = 64'h00_00_00_46_49_51_61_42;
      4'd3:    row = 64'h00_00_00_31_4B_45_41_21;
      4'd4:    row = 64'h00_00_00_10_7F_12_14_18;
      4'd5:    row = 64'h00_00_00_39_45_45_45_27;
      4'd6:    row = 64'h00_00_00_30_49_49_4A_3C;
      4'd7:    row = 64'h00_00_00_03_05_09_71_01;
      4'd8:    row = 64'h00_00_00_36_49_49_49_36;
      4'd9:    row = 64'h00_00_00_1E_29_49_49_06;
      4'd10:   row = 64'h00_00_00_00_00_14_00_00;
      4'd11:   row = 64'h00_00_00_3C_3C_00_00_00;
      default: row = '0;
    endcase
    return row[{c, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] double_nibble(logic [3:0] n);
    return {n[3], n[3], n[2], n[2], n[1], n[1], n[0], n[0]};
  endfunction

endpackage

// ===== rtl/dgpr_if.sv =====
// Valid/ready channel interfaces: draw requests in, display bytes out.
// No dependencies.
interface dgpr_req_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [2:0] page;
  logic [6:0] column;
  logic [7:0] code;

  modport source (output valid, kind, page, column, code, input ready);
  modport sink   (input valid, kind, page, column, code, output ready);
endinterface

interface dgpr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_data;
  logic       last;

  modport source (output valid, out_byte, is_data, last, input ready);
  modport sink   (input valid, out_byte, is_data, last, output ready);
endinterface

// ===== rtl/dgpr_front.sv =====
// Request front end: decodes the character code, drops undrawable requests,
// hands drawable jobs to the queue. Uses dgpr_pkg and dgpr_req_if.
module dgpr_front (
  dgpr_req_if.sink        req_i,
  output dgpr_pkg::push_t push_o,
  input  logic            push_ready_i
);

  logic [4:0] cls;

  assign cls = dgpr_pkg::classify(req_i.kind, req_i.code);

  // undrawable requests are taken and go nowhere
  assign req_i.ready        = push_ready_i;
  assign push_o.valid       = req_i.valid && cls[4];
  assign push_o.job.kind    = req_i.kind;
  assign push_o.job.page    = req_i.page;
  assign push_o.job.column  = req_i.column;
  assign push_o.job.glyph   = cls[3:0];

endmodule

// ===== rtl/dgpr_queue.sv =====
// Small job queue between the front end and the byte sequencer.
// Uses dgpr_pkg.
module dgpr_queue #(
  parameter int Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dgpr_pkg::push_t push_i,
  output logic            push_ready_o,
  output logic            pop_valid_o,
  output dgpr_pkg::job_t  pop_job_o,
  input  logic            pop_i
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  dgpr_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_job_o    = mem_q[rd_ptr_q];
  assign do_push      = push_i.valid && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.job;
    end
  end

endmodule

// ===== rtl/dgpr_back.sv =====
// Byte sequencer: walks one job through its page commands and column bytes,
// one byte per cycle into the output register unless stalled. Uses dgpr_pkg, dgpr_out_if.
module dgpr_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  dgpr_pkg::job_t job_i,
  output logic           pop_o,
  dgpr_out_if.source     res_o
);

  dgpr_pkg::job_t job_q;
  logic           busy_q;
  logic           sel_q;
  logic [4:0]     step_q;
  logic           ovalid_q;
  logic [7:0]     obyte_q;
  logic           odata_q, olast_q;

  logic       adv, load, is_last, page_end;
  logic [4:0] dstep;
  logic [2:0] gcol;
  logic [7:0] rom_byte, cur_byte;
  logic [3:0] nib;
  logic       cur_data;

  always_comb begin
    adv      = !ovalid_q || res_o.ready;
    is_last  = (job_q.kind == dgpr_pkg::KindLarge)
             ? (sel_q && step_q == dgpr_pkg::StepLastLarge)
             : (step_q == dgpr_pkg::StepLastSmall);
    page_end = (job_q.kind == dgpr_pkg::KindLarge) && !sel_q
             && (step_q == dgpr_pkg::StepLastLarge);
    load     = adv && (!busy_q || is_last);
    pop_o    = load && job_valid_i;

    dstep    = step_q - dgpr_pkg::StepFirstData;
    // large glyphs send every column twice
    gcol     = (job_q.kind == dgpr_pkg::KindLarge) ? dstep[3:1] : dstep[2:0];
    rom_byte = dgpr_pkg::glyph_col(job_q.glyph, gcol);
    nib      = sel_q ? rom_byte[7:4] : rom_byte[3:0];

    cur_data = 1'b1;
    if (step_q == '0) begin
      cur_data = 1'b0;
      cur_byte = dgpr_pkg::CmdPageBase + {5'b0, job_q.page} + {7'b0, sel_q};
    end else if (step_q == dgpr_pkg::StepColLow) begin
      cur_data = 1'b0;
      cur_byte = {dgpr_pkg::CmdColLow, job_q.column[3:0]};
    end else if (step_q == dgpr_pkg::StepColHigh) begin
      cur_data = 1'b0;
      cur_byte = {dgpr_pkg::CmdColHigh, 1'b0, job_q.column[6:4]};
    end else if (job_q.kind == dgpr_pkg::KindLarge) begin
      cur_byte = dgpr_pkg::double_nibble(nib);
    end else begin
      cur_byte = rom_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      ovalid_q <= 1'b0;
      sel_q    <= 1'b0;
      step_q   <= '0;
    end else if (adv) begin
      ovalid_q <= busy_q;
      if (busy_q && !is_last) begin
        if (page_end) begin
          sel_q  <= 1'b1;
          step_q <= '0;
        end else begin
          step_q <= step_q + 1'b1;
        end
      end
      if (load) begin
        busy_q <= job_valid_i;
        sel_q  <= 1'b0;
        step_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    if (adv) begin
      obyte_q <= cur_byte;
      odata_q <= cur_data;
      olast_q <= is_last;
    end
  end

  assign res_o.valid    = ovalid_q;
  assign res_o.out_byte = obyte_q;
  assign res_o.is_data  = odata_q;
  assign res_o.last     = olast_q;

endmodule

// ===== rtl/digit_glyph_page_renderer.sv =====
// Top level of the digit glyph page renderer: front end, job queue, sequencer.
// Uses dgpr_pkg, dgpr_if, dgpr_front, dgpr_queue, dgpr_back and the defines.
//
//  channel  | dir | handshake   | payload
//  req_i    | in  | valid/ready | kind, page, column, code
//  res_o    | out | valid/ready | out_byte, is_data, last
//
// One byte leaves per cycle unless res_o stalls: a small glyph is 11 bytes,
// a large one 38; the byte sequencer sets those counts. Consecutive glyphs
// follow with no gap. An undrawable request is taken and yields nothing.
// Reset clears the queue and sequencer control; no clearing pass.
// Requests are taken while the job queue has room, also during output stalls.
`include "digit_glyph_page_renderer_defines.svh"

module digit_glyph_page_renderer #(
  parameter int QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dgpr_req_if.sink   req_i,
  dgpr_out_if.source res_o
);

  dgpr_pkg::push_t push;
  logic            push_ready;
  logic            q_valid;
  dgpr_pkg::job_t  q_job;
  logic            pop;
  logic [4:0]      req_cls;
  logic            last_taken;

  dgpr_front u_front (
    .req_i        (req_i),
    .push_o       (push),
    .push_ready_i (push_ready)
  );

  dgpr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .pop_valid_o  (q_valid),
    .pop_job_o    (q_job),
    .pop_i        (pop)
  );

  dgpr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (q_job),
    .pop_o       (pop),
    .res_o       (res_o)
  );

  assign req_cls    = dgpr_pkg::classify(req_i.kind, req_i.code);
  assign last_taken = res_o.valid && res_o.ready && res_o.last;

  `DGPR_ASSERT_IMP(a_no_push_undrawable, clk_i, rst_ni, req_i.valid && !req_cls[4], !push.valid)
  `DGPR_ASSERT_IMP(a_pop_needs_job, clk_i, rst_ni, pop, q_valid)
  `DGPR_ASSERT_IMP(a_last_is_data, clk_i, rst_ni, res_o.valid && res_o.last, res_o.is_data)
  `DGPR_ASSERT_NXT(a_run_opens_cmd, clk_i, rst_ni, last_taken, !res_o.valid || !res_o.is_data)

endmodule

// ===== dv/dgpr_glyph_checker.sv =====
// Checker for the digit glyph page renderer: watches both channels, predicts
// the display byte stream of each accepted request and compares it in order.
// Depends on dgpr_pkg and the dgpr_req_if / dgpr_out_if interfaces.
module dgpr_glyph_checker (
  input  logic clk_i,
  input  logic rst_ni,
  dgpr_req_if  req_mon,
  dgpr_out_if  res_mon,
  output int   fail_count_o,
  output int   pending_o,
  output int   small_glyphs_o,
  output int   large_glyphs_o,
  output int   skipped_o,
  output int   bytes_checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] value;
    logic       is_data;
    logic       last;
  } disp_byte_t;

  disp_byte_t display_due[$];
  int fail_count    = 0;
  int pending_q     = 0;
  int small_glyphs  = 0;
  int large_glyphs  = 0;
  int skipped       = 0;
  int bytes_checked = 0;

  assign fail_count_o    = fail_count;
  assign pending_o       = pending_q;
  assign small_glyphs_o  = small_glyphs;
  assign large_glyphs_o  = large_glyphs;
  assign skipped_o       = skipped;
  assign bytes_checked_o = bytes_checked;

  // column 0 in the top byte, bit 0 of each column is the top pixel row
  function automatic logic [7:0] font_column(logic [3:0] glyph, int unsigned col);
    logic [63:0] cols;
    case (glyph)
      4'd0:                 cols = 64'h3E51_4945_3E00_0000;
      4'd1:                 cols = 64'h0042_7F40_0000_0000;
      4'd2:                 cols = 64'h4261_5149_4600_0000;
      4'd3:                 cols = 64'h2141_454B_3100_0000;
      4'd4:                 cols = 64'h1814_127F_1000_0000;
      4'd5:                 cols = 64'h2745_4545_3900_0000;
      4'd6:                 cols = 64'h3C4A_4949_3000_0000;
      4'd7:                 cols = 64'h0171_0905_0300_0000;
      4'd8:                 cols = 64'h3649_4949_3600_0000;
      4'd9:                 cols = 64'h0649_4929_1E00_0000;
      dgpr_pkg::GlyphColon: cols = 64'h0000_1400_0000_0000;
      dgpr_pkg::GlyphDash:  cols = 64'h0000_003C_3C00_0000;
      default:              cols = '0;
    endcase
    return cols[63 - 8 * col -: 8];
  endfunction

  function automatic logic [7:0] stretch_nibble(logic [3:0] nib);
    logic [7:0] wide;
    wide = '0;
    for (int b = 0; b < 4; b++) begin
      wide[2 * b]     = nib[b];
      wide[2 * b + 1] = nib[b];
    end
    return wide;
  endfunction

  task automatic push_address(logic [7:0] page_cmd, logic [6:0] column);
    display_due.push_back(disp_byte_t'{page_cmd, 1'b0, 1'b0});
    display_due.push_back(disp_byte_t'{{dgpr_pkg::CmdColLow, column[3:0]}, 1'b0, 1'b0});
    display_due.push_back(disp_byte_t'{{dgpr_pkg::CmdColHigh, 1'b0, column[6:4]},
                                       1'b0, 1'b0});
  endtask

  task automatic predict_glyph(logic kind, logic [2:0] page, logic [6:0] column,
                               logic [7:0] code);
    logic [3:0] glyph;
    logic       drawable;
    logic [7:0] pix;
    disp_byte_t tail;
    drawable = 1'b1;
    glyph    = '0;
    if (code >= dgpr_pkg::CharZero && code <= dgpr_pkg::CharNine) begin
      glyph = 4'(code - dgpr_pkg::CharZero);
    end else if (code == dgpr_pkg::CharColon) begin
      glyph = dgpr_pkg::GlyphColon;
    end else if (code == dgpr_pkg::CharSlash && kind == dgpr_pkg::KindLarge) begin
      glyph = dgpr_pkg::GlyphDash;
    end else begin
      drawable = 1'b0;
    end
    if (!drawable) begin
      skipped++;
    end else if (kind == dgpr_pkg::KindSmall) begin
      small_glyphs++;
      push_address(dgpr_pkg::CmdPageBase + 8'(page), column);
      for (int c = 0; c < 8; c++) begin
        display_due.push_back(disp_byte_t'{font_column(glyph, c), 1'b1, 1'b0});
      end
    end else begin
      large_glyphs++;
      // second page at page 7 gives 0xB8, no wrap
      for (int p = 0; p < 2; p++) begin
        push_address(dgpr_pkg::CmdPageBase + 8'(page) + 8'(p), column);
        for (int c = 0; c < 8; c++) begin
          pix = font_column(glyph, c);
          pix = stretch_nibble(p == 0 ? pix[3:0] : pix[7:4]);
          display_due.push_back(disp_byte_t'{pix, 1'b1, 1'b0});
          display_due.push_back(disp_byte_t'{pix, 1'b1, 1'b0});
        end
      end
    end
    if (drawable) begin
      tail = display_due.pop_back();
      tail.last = 1'b1;
      display_due.push_back(tail);
    end
  endtask

  always @(posedge clk_i) begin
    disp_byte_t want;
    if (rst_ni) begin
      if (res_mon.valid && res_mon.ready) begin
        bytes_checked++;
        if (display_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: unexpected display byte %02h is_data %0b last %0b",
                     $realtime, res_mon.out_byte, res_mon.is_data, res_mon.last);
          end
        end else begin
          want = display_due.pop_front();
          if (res_mon.out_byte !== want.value || res_mon.is_data !== want.is_data ||
              res_mon.last !== want.last) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: display byte mismatch: expected %02h/%0b/%0b got %02h/%0b/%0b",
                       $realtime, want.value, want.is_data, want.last,
                       res_mon.out_byte, res_mon.is_data, res_mon.last);
            end
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        predict_glyph(req_mon.kind, req_mon.page, req_mon.column, req_mon.code);
      end
      pending_q <= display_due.size();
    end
  end

endmodule

// ===== dv/tb_digit_glyph_page_renderer.sv =====
// Top of the digit glyph page renderer testbench: clock, reset, draw requests
// with random gaps and output stalls, and the verdict.
// Depends on dgpr_pkg, the channel interfaces, the RTL and dgpr_glyph_checker.
module tb_digit_glyph_page_renderer;
  timeunit 1ns;
  timeprecision 1ps;

  // random requests after the 26 directed ones
  localparam int RandomDraws = 334;
  localparam int DrainCycles = 100;
  localparam int CycleLimit  = 200000;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic quiet = 1'b0;   // no idling on either side while set
  int   cycle_count = 0;
  int   fail_count, pending, small_glyphs, large_glyphs, skipped, bytes_checked;

  dgpr_req_if req_if ();
  dgpr_out_if res_if ();

  digit_glyph_page_renderer i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  dgpr_glyph_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_mon         (req_if),
    .res_mon         (res_if),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .small_glyphs_o  (small_glyphs),
    .large_glyphs_o  (large_glyphs),
    .skipped_o       (skipped),
    .bytes_checked_o (bytes_checked)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    res_if.ready <= quiet || ($urandom_range(0, 99) >= 36);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d display bytes still due", cycle_count, pending);
      $display("tb_digit_glyph_page_renderer NOT OK");
      $finish;
    end
  end

  task automatic send_request(logic kind, logic [2:0] page, logic [6:0] column,
                              logic [7:0] code);
    while (!quiet && $urandom_range(0, 99) < 36) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid  <= 1'b1;
    req_if.kind   <= kind;
    req_if.page   <= page;
    req_if.column <= column;
    req_if.code   <= code;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  task automatic wait_for_idle();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    logic       kind;
    logic [2:0] page;
    logic [6:0] column;
    logic [7:0] code;
    int         pick;
    int         draws;
    rst_ni        = 1'b0;
    req_if.valid  = 1'b0;
    req_if.kind   = dgpr_pkg::KindSmall;
    req_if.page   = '0;
    req_if.column = '0;
    req_if.code   = '0;
    res_if.ready  = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every digit in both sizes at page 0 or 7 and at column 0, 127 or a middle column
    for (int d = 0; d < 10; d++) begin
      send_request(dgpr_pkg::KindSmall, (d % 2) ? 3'd7 : 3'd0,
                   (d % 3 == 0) ? 7'd0 : (d % 3 == 1) ? 7'd127 : 7'(d * 13),
                   dgpr_pkg::CharZero + 8'(d));
    end
    for (int d = 0; d < 10; d++) begin
      send_request(dgpr_pkg::KindLarge, (d % 2) ? 3'd0 : 3'd7,
                   (d % 3 == 0) ? 7'd127 : (d % 3 == 1) ? 7'd0 : 7'(d * 11),
                   dgpr_pkg::CharZero + 8'(d));
    end
    send_request(dgpr_pkg::KindSmall, 3'd7, 7'd127, dgpr_pkg::CharColon);
    send_request(dgpr_pkg::KindLarge, 3'd7, 7'd0, dgpr_pkg::CharColon);
    send_request(dgpr_pkg::KindLarge, 3'd3, 7'd64, dgpr_pkg::CharSlash);
    // undrawable: slash in small size, codes outside the font
    send_request(dgpr_pkg::KindSmall, 3'd5, 7'd42, dgpr_pkg::CharSlash);
    send_request(dgpr_pkg::KindSmall, 3'd0, 7'd0, 8'h00);
    send_request(dgpr_pkg::KindLarge, 3'd7, 7'd127, 8'hFF);
    wait_for_idle();

    draws = 0;
    while (draws < RandomDraws) begin
      quiet = (draws >= 120 && draws < 200);
      if (draws == 260) begin
        wait_for_idle();
      end
      kind   = 1'($urandom_range(0, 1));
      page   = 3'($urandom_range(0, 7));
      column = 7'($urandom_range(0, 127));
      pick   = $urandom_range(0, 99);
      if (pick < 70) begin
        code = dgpr_pkg::CharZero + 8'($urandom_range(0, 9));
      end else if (pick < 78) begin
        code = dgpr_pkg::CharColon;
      end else if (pick < 86) begin
        code = dgpr_pkg::CharSlash;
      end else begin
        code = 8'($urandom_range(0, 255));
      end
      send_request(kind, page, column, code);
      draws++;
    end
    quiet = 1'b0;

    wait_for_idle();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Drew %0d small and %0d large glyphs, %0d requests were undrawable;",
             small_glyphs, large_glyphs, skipped);
    $display("%0d display bytes checked, %0d mismatches.", bytes_checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_digit_glyph_page_renderer OK");
    end else begin
      $display("tb_digit_glyph_page_renderer NOT OK");
    end
    $finish;
  end

endmodule
